>>> design/beq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the button/encoder event qualifier.
// No dependencies; every other design file imports this package except beq_event_if.
package beq_pkg;

	// Fixed widths of the channel payloads
	localparam int NOW_W    = 32;
	localparam int CNT_IN_W = 32;
	localparam int MS_W     = 16;
	localparam int PPD_W    = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	// Register values after reset
	localparam logic [MS_W-1:0]  DEBOUNCE_RST   = 16'd50;
	localparam logic [MS_W-1:0]  LONG_PRESS_RST = 16'd600;
	localparam logic [MS_W-1:0]  ENC_POLL_RST   = 16'd10;
	localparam logic [PPD_W-1:0] PPD_RST        = 8'd4;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE   = 2'd0,
		CFG_LONG_PRESS = 2'd1,
		CFG_ENC_POLL   = 2'd2,
		CFG_PPD        = 2'd3
	} cfg_index_t;

	// Event codes on the result channel
	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_YES      = 3'd1,
		EV_NO       = 3'd2,
		EV_LONG_YES = 3'd3,
		EV_LONG_NO  = 3'd4,
		EV_UP       = 3'd5,
		EV_DOWN     = 3'd6
	} event_code_t;

	// Current register settings, fanned out to the units
	typedef struct packed {
		logic [MS_W-1:0]  debounce_win;
		logic [MS_W-1:0]  long_hold;
		logic [MS_W-1:0]  enc_interval;
		logic [PPD_W-1:0] pulses_per_detent;
	} cfg_regs_t;

	// What one button reports for one poll
	typedef struct packed {
		logic short_fire;
		logic long_fire;
	} btn_evt_t;

	// What the encoder unit reports for one poll
	typedef struct packed {
		logic up;
		logic down;
	} enc_evt_t;

endpackage

>>> design/beq_poll_if.sv
`timescale 1ns / 1ps
// Poll channel: one timestamped sample of both buttons and the encoder count.
// Depends on beq_pkg for payload widths.
interface beq_poll_if import beq_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [NOW_W-1:0]    now_ms;
	logic                yes_level;
	logic                no_level;
	logic signed [CNT_IN_W-1:0] encoder_count;

	modport source(output valid, now_ms, yes_level, no_level, encoder_count, input ready);
	modport sink(input valid, now_ms, yes_level, no_level, encoder_count, output ready);
endinterface

>>> design/beq_event_if.sv
`timescale 1ns / 1ps
// Event channel: one event code per poll.
// Depends on nothing outside this file.
interface beq_event_if ();
	logic       valid;
	logic       ready;
	logic [2:0] event_code;

	modport source(output valid, event_code, input ready);
	modport sink(input valid, event_code, output ready);
endinterface

>>> design/beq_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
// Depends on beq_pkg for field widths.
interface beq_cfg_if import beq_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] reg_index;
	logic [CFG_DAT_W-1:0] data;

	modport source(output valid, reg_index, data, input ready);
	modport sink(input valid, reg_index, data, output ready);
endinterface

>>> design/beq_button.sv
`timescale 1ns / 1ps
// One debounced button with short and long press detection.
// Depends on beq_pkg for the config and event structs.
module beq_button import beq_pkg::*; #(
	parameter int TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 poll_en,
	input  logic [TIME_BITS-1:0] now,
	input  logic                 level,
	input  cfg_regs_t            cfg,
	output btn_evt_t             evt
);

	logic                 stable_q;
	logic [TIME_BITS-1:0] change_time_q;
	logic                 held_q;
	logic [TIME_BITS-1:0] hold_start_q;
	logic                 long_done_q;

	logic                 accept;
	logic                 press;
	logic                 held_a;
	logic [TIME_BITS-1:0] hold_start_a;
	logic                 long_done_a;
	logic [TIME_BITS-1:0] since_change;
	logic [TIME_BITS-1:0] since_hold;

	// Qualify a level change against the debounce window
	always_comb begin
		since_change = now - change_time_q;
		accept = (level != stable_q) &&
			(since_change > TIME_BITS'(cfg.debounce_win));
		press = accept && !level;
		held_a = accept ? !level : held_q;
		hold_start_a = press ? now : hold_start_q;
		long_done_a = press ? 1'b0 : long_done_q;
		since_hold = now - hold_start_a;
	end

	// Short press on release, otherwise check the hold time
	always_comb begin
		evt.short_fire = accept && level && held_q && !long_done_q;
		evt.long_fire = !evt.short_fire && held_a && !long_done_a &&
			(since_hold >= TIME_BITS'(cfg.long_hold));
	end

	// Commit the button state when this button is polled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q      <= 1'b1;
			change_time_q <= '0;
			held_q        <= 1'b0;
			hold_start_q  <= '0;
			long_done_q   <= 1'b0;
		end else if (poll_en) begin
			if (accept) begin
				stable_q      <= level;
				change_time_q <= now;
			end
			held_q       <= held_a;
			hold_start_q <= hold_start_a;
			long_done_q  <= long_done_a | evt.long_fire;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		poll_en && evt.long_fire |=> long_done_q)
		else $error("long press fired but not marked done");

	assert property (@(posedge clk) disable iff (!arst_n)
		!(evt.short_fire && evt.long_fire))
		else $error("short and long press in the same poll");

	assert property (@(posedge clk) disable iff (!arst_n)
		poll_en && press |=> held_q && !stable_q)
		else $error("accepted press did not start a hold");

endmodule

>>> design/beq_encoder.sv
`timescale 1ns / 1ps
// Rotary encoder detent tracker, sampled no faster than the poll interval.
// Depends on beq_pkg for the config and event structs.
module beq_encoder import beq_pkg::*; #(
	parameter int TIME_BITS  = 32,
	parameter int COUNT_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  poll_en,
	input  logic [TIME_BITS-1:0]  now,
	input  logic [COUNT_BITS-1:0] count,
	input  cfg_regs_t             cfg,
	output enc_evt_t              evt
);

	logic [TIME_BITS-1:0]  sample_time_q;
	logic [COUNT_BITS-1:0] base_q;

	logic                  sample;
	logic [TIME_BITS-1:0]  since_sample;
	logic [PPD_W-1:0]      ppd;
	logic [COUNT_BITS-1:0] ppd_ext;
	logic [COUNT_BITS-1:0] delta;

	// Compare the count against the detent base, zero detent size acts as one
	always_comb begin
		since_sample = now - sample_time_q;
		sample = poll_en && (since_sample > TIME_BITS'(cfg.enc_interval));
		ppd = (cfg.pulses_per_detent == '0) ? PPD_W'(1) : cfg.pulses_per_detent;
		ppd_ext = COUNT_BITS'(ppd);
		delta = count - base_q;
		evt.down = sample && ($signed(delta) >= $signed(ppd_ext));
		evt.up = sample && !evt.down && ($signed(delta) <= -$signed(ppd_ext));
	end

	// Move the base one detent per sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_time_q <= '0;
			base_q        <= '0;
		end else if (sample) begin
			sample_time_q <= now;
			if (evt.down) begin
				base_q <= base_q + ppd_ext;
			end else if (evt.up) begin
				base_q <= base_q - ppd_ext;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		evt.down |=> base_q == $past(base_q) + $past(ppd_ext))
		else $error("down step did not advance the base");

	assert property (@(posedge clk) disable iff (!arst_n)
		!sample |=> $stable(base_q))
		else $error("base moved without a sample");

	assert property (@(posedge clk) disable iff (!arst_n)
		!(evt.up && evt.down))
		else $error("up and down in the same sample");

endmodule

>>> design/button_encoder_event_qualifier.sv
`timescale 1ns / 1ps
// Debounced two-button and rotary encoder event qualifier.
// Depends on beq_pkg, the three channel interfaces, beq_button, beq_encoder.
//
// Channels: poll (sink) brings a millisecond timestamp, the active-low yes
// and no button levels and the signed encoder count. evt (source) returns
// exactly one event code per poll: none, yes, no, long yes, long no, up or
// down, with yes over no over encoder. cfg (sink) writes the debounce window,
// the long-press time, the encoder poll interval and the detent size by
// index; it is always ready and is meant to be written while no poll is in
// flight.
//
// A poll is first held in the poll register; its event then loads into the
// result register, from which the receiver takes it.
// Throughput: one poll per cycle unless the receiver stalls. A poll register
// feeds the event logic, which commits button and encoder state in the same
// cycle it loads the result register, so the next poll sees updated state.
//
// Reset (arst_n low): registers return to 50 / 600 / 10 / 4, both buttons
// read released with all times at zero, and both stages empty.
// Receiver stall: the result holds; the poll register still fills, then
// poll.ready drops until the result is taken.
module button_encoder_event_qualifier import beq_pkg::*; #(
	parameter int TIME_BITS  = 32,
	parameter int COUNT_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	beq_cfg_if.sink       cfg,
	beq_poll_if.sink      poll,
	beq_event_if.source   evt
);

	cfg_regs_t             cfg_q;

	logic                  valid_s1;
	logic [TIME_BITS-1:0]  now_s1;
	logic                  yes_s1;
	logic                  no_s1;
	logic [COUNT_BITS-1:0] count_s1;

	logic                  out_valid_q;
	event_code_t           event_q;

	logic                  step;
	logic                  no_poll;
	logic                  enc_poll;
	btn_evt_t              yes_evt;
	btn_evt_t              no_evt;
	enc_evt_t              enc_evt;
	event_code_t           event_d;

	// Configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_win      <= DEBOUNCE_RST;
			cfg_q.long_hold         <= LONG_PRESS_RST;
			cfg_q.enc_interval      <= ENC_POLL_RST;
			cfg_q.pulses_per_detent <= PPD_RST;
		end else if (cfg.valid) begin
			unique case (cfg_index_t'(cfg.reg_index))
				CFG_DEBOUNCE:   cfg_q.debounce_win      <= cfg.data;
				CFG_LONG_PRESS: cfg_q.long_hold         <= cfg.data;
				CFG_ENC_POLL:   cfg_q.enc_interval      <= cfg.data;
				CFG_PPD:        cfg_q.pulses_per_detent <= cfg.data[PPD_W-1:0];
			endcase
		end
	end

	// Handshake: advance the poll stage whenever the result register frees up
	assign step       = valid_s1 && (!out_valid_q || evt.ready);
	assign poll.ready = !valid_s1 || step;

	// Hold the accepted poll
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.ready && poll.valid) begin
			now_s1   <= TIME_BITS'(poll.now_ms);
			yes_s1   <= poll.yes_level;
			no_s1    <= poll.no_level;
			count_s1 <= COUNT_BITS'(poll.encoder_count);
		end
	end

	// Yes is always polled; no only if yes is quiet; encoder only if both are
	assign no_poll  = step && !yes_evt.short_fire && !yes_evt.long_fire;
	assign enc_poll = no_poll && !no_evt.short_fire && !no_evt.long_fire;

	beq_button #(.TIME_BITS(TIME_BITS)) u_yes (
		.clk     (clk),
		.arst_n  (arst_n),
		.poll_en (step),
		.now     (now_s1),
		.level   (yes_s1),
		.cfg     (cfg_q),
		.evt     (yes_evt)
	);

	beq_button #(.TIME_BITS(TIME_BITS)) u_no (
		.clk     (clk),
		.arst_n  (arst_n),
		.poll_en (no_poll),
		.now     (now_s1),
		.level   (no_s1),
		.cfg     (cfg_q),
		.evt     (no_evt)
	);

	beq_encoder #(.TIME_BITS(TIME_BITS), .COUNT_BITS(COUNT_BITS)) u_enc (
		.clk     (clk),
		.arst_n  (arst_n),
		.poll_en (enc_poll),
		.now     (now_s1),
		.count   (count_s1),
		.cfg     (cfg_q),
		.evt     (enc_evt)
	);

	// Pick the single event in priority order
	always_comb begin
		priority if (yes_evt.short_fire) begin
			event_d = EV_YES;
		end else if (yes_evt.long_fire) begin
			event_d = EV_LONG_YES;
		end else if (no_evt.short_fire) begin
			event_d = EV_NO;
		end else if (no_evt.long_fire) begin
			event_d = EV_LONG_NO;
		end else if (enc_evt.up) begin
			event_d = EV_UP;
		end else if (enc_evt.down) begin
			event_d = EV_DOWN;
		end else begin
			event_d = EV_NONE;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (evt.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			event_q <= event_d;
		end
	end

	assign evt.valid      = out_valid_q;
	assign evt.event_code = event_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid_q)
		else $error("poll advanced without loading a result");

	assert property (@(posedge clk) disable iff (!arst_n)
		!poll.ready |-> valid_s1 && out_valid_q && !evt.ready)
		else $error("poll stalled with room downstream");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !evt.ready |=> valid_s1 && $stable(now_s1))
		else $error("held poll was lost under a stall");

endmodule
